>>> sv/urlrb_pkg.sv
// Shared constants, codes and types of the receive line ring buffer.
package urlrb_pkg;

  localparam int DEPTH    = 1024;
  localparam int AW       = $clog2(DEPTH);
  localparam int FW       = AW + 1;
  localparam int MAX_LINE = 64;
  localparam int CAP_W    = 7;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_STORED     = 3'd0,
    STS_DROP_FULL  = 3'd1,
    STS_DROP_NUL   = 3'd2,
    STS_LINE_BYTE  = 3'd3,
    STS_NO_LINE    = 3'd4,
    STS_EMPTY_LINE = 3'd5,
    STS_FLUSHED    = 3'd6
  } status_t;

  localparam logic [1:0] CFG_NUL_FILTER   = 2'd0;
  localparam logic [1:0] CFG_MAX_LINE_LEN = 2'd1;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } ram_wr_t;

endpackage

>>> sv/urlrb_ram.sv
// Byte store: single write port, one registered read port.
module urlrb_ram (
  input  logic                    clk,
  input  urlrb_pkg::ram_wr_t      wr,
  input  logic [urlrb_pkg::AW-1:0] rd_addr,
  output logic [7:0]              rd_data
);

  logic [7:0] mem [urlrb_pkg::DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/uart_rx_line_ring_buffer_unit.sv
// Receive ring buffer for a serial console with newline-delimited line extraction.
// A byte, flush or empty-store get-line result goes through a pending register and then the
// output register; otherwise a get-line scans one stored byte per cycle, answering no line when
// none of the stored bytes is a newline, or else hands out the line one byte per cycle while the
// output is free. No new request is taken until the last result is in the output register.
// Reset (synchronous, rst_n low) clears pointers, full flag, state and out_tvalid, enables the
// zero-byte filter and sets max_line_len to 64; other registers and the byte store are not reset.
module uart_rx_line_ring_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: tuser = req_type[1:0]; tdata = rx_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  // Result stream: tdata = line_byte[7:0], fill_level[18:8], zero[23:19];
  // tuser = status[2:0]; tlast = last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  // Configuration writes: index 0 zero-byte filter enable, index 1 max_line_len
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW    = urlrb_pkg::AW;
  localparam int FW    = urlrb_pkg::FW;
  localparam int CAP_W = urlrb_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_SCAN,
    S_HAND
  } state_t;

  // Fill level from the two pointers; equal pointers mean empty unless the full flag is set.
  function automatic logic [FW-1:0] fill_of(logic [AW-1:0] w, logic [AW-1:0] r, logic f);
    logic [FW-1:0] res;
    if (f) begin
      res = FW'(urlrb_pkg::DEPTH);
    end else begin
      res = {1'b0, AW'(w - r)};
    end
    return res;
  endfunction

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          rp_r, rp_nxt;
  logic                   full_r, full_nxt;
  logic                   cmd_mode_r, cmd_mode_nxt;
  logic [CAP_W-1:0]       max_len_r, max_len_nxt;

  // Scan and hand-out bookkeeping.
  logic [FW-1:0]          have_r, have_nxt;
  logic [AW-1:0]          len_r, len_nxt;
  logic [CAP_W-1:0]       take_r, take_nxt;
  logic [CAP_W-1:0]       k_r, k_nxt;
  logic [AW-1:0]          line_end_r, line_end_nxt;

  // Single result waiting to go to the output register.
  urlrb_pkg::status_t     pend_status_r, pend_status_nxt;
  logic [FW-1:0]          pend_fill_r, pend_fill_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  urlrb_pkg::status_t     out_status_r, out_status_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [FW-1:0]          out_fill_r, out_fill_nxt;

  urlrb_pkg::ram_wr_t     ram_wr;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             mem_q;

  logic                   out_free;
  logic                   in_xfer;
  logic [CAP_W-1:0]       cap;
  logic [AW-1:0]          wp_inc;
  logic                   full_after_store;

  urlrb_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // The line cap treats zero as one and anything above the limit as the limit.
  always_comb begin
    if (max_len_r == '0) begin
      cap = CAP_W'(1);
    end else if (max_len_r > CAP_W'(urlrb_pkg::MAX_LINE)) begin
      cap = CAP_W'(urlrb_pkg::MAX_LINE);
    end else begin
      cap = max_len_r;
    end
  end

  assign wp_inc           = AW'(wp_r + AW'(1));
  assign full_after_store = (wp_inc == rp_r);

  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    full_nxt        = full_r;
    cmd_mode_nxt    = cmd_mode_r;
    max_len_nxt     = max_len_r;
    have_nxt        = have_r;
    len_nxt         = len_r;
    take_nxt        = take_r;
    k_nxt           = k_r;
    line_end_nxt    = line_end_r;
    pend_status_nxt = pend_status_r;
    pend_fill_nxt   = pend_fill_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    out_fill_nxt    = out_fill_r;
    ram_wr          = '0;
    rd_addr         = rp_r;

    // Configuration transfers are taken in any state.
    if (cfg_valid) begin
      unique case (cfg_index)
        urlrb_pkg::CFG_NUL_FILTER:   cmd_mode_nxt = cfg_data[0];
        urlrb_pkg::CFG_MAX_LINE_LEN: max_len_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // The read of the byte at the read pointer is already under way for a scan.
        if (in_xfer) begin
          case (urlrb_pkg::req_t'(in_tuser))
            urlrb_pkg::REQ_BYTE: begin
              if (full_r) begin
                pend_status_nxt = urlrb_pkg::STS_DROP_FULL;
                pend_fill_nxt   = fill_of(wp_r, rp_r, full_r);
              end else if (cmd_mode_r && in_tdata == 8'h00) begin
                pend_status_nxt = urlrb_pkg::STS_DROP_NUL;
                pend_fill_nxt   = fill_of(wp_r, rp_r, full_r);
              end else begin
                ram_wr.we       = 1'b1;
                ram_wr.addr     = wp_r;
                ram_wr.data     = in_tdata;
                wp_nxt          = wp_inc;
                full_nxt        = full_after_store;
                pend_status_nxt = urlrb_pkg::STS_STORED;
                pend_fill_nxt   = fill_of(wp_inc, rp_r, full_after_store);
              end
              state_nxt = S_EMIT;
            end
            urlrb_pkg::REQ_LINE: begin
              if (fill_of(wp_r, rp_r, full_r) == '0) begin
                pend_status_nxt = urlrb_pkg::STS_NO_LINE;
                pend_fill_nxt   = '0;
                state_nxt       = S_EMIT;
              end else begin
                have_nxt  = fill_of(wp_r, rp_r, full_r);
                len_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // Flush, and the unused request code behaves the same way.
              wp_nxt          = '0;
              rp_nxt          = '0;
              full_nxt        = 1'b0;
              pend_status_nxt = urlrb_pkg::STS_FLUSHED;
              pend_fill_nxt   = '0;
              state_nxt       = S_EMIT;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_byte_nxt   = 8'h00;
          out_last_nxt   = 1'b1;
          out_fill_nxt   = pend_fill_r;
          state_nxt      = S_IDLE;
        end
      end

      S_SCAN: begin
        // mem_q holds the byte at offset len_r; the next offset is fetched meanwhile.
        rd_addr = AW'(rp_r + len_r + AW'(1));
        if (mem_q == urlrb_pkg::NEWLINE) begin
          if (len_r == '0) begin
            rp_nxt          = AW'(rp_r + AW'(1));
            full_nxt        = 1'b0;
            pend_status_nxt = urlrb_pkg::STS_EMPTY_LINE;
            pend_fill_nxt   = fill_of(wp_r, AW'(rp_r + AW'(1)), 1'b0);
            state_nxt       = S_EMIT;
          end else begin
            if (len_r < AW'(cap)) begin
              take_nxt = CAP_W'(len_r);
            end else begin
              take_nxt = cap;
            end
            line_end_nxt = AW'(rp_r + len_r + AW'(1));
            k_nxt        = '0;
            rd_addr      = rp_r;
            state_nxt    = S_HAND;
          end
        end else if ({1'b0, len_r} + FW'(1) == have_r) begin
          pend_status_nxt = urlrb_pkg::STS_NO_LINE;
          pend_fill_nxt   = have_r;
          state_nxt       = S_EMIT;
        end else begin
          len_nxt = AW'(len_r + AW'(1));
        end
      end

      S_HAND: begin
        // mem_q holds the byte at the read pointer; on a stall the same address is reread.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = urlrb_pkg::STS_LINE_BYTE;
          out_byte_nxt   = mem_q;
          full_nxt       = 1'b0;
          if (CAP_W'(k_r + CAP_W'(1)) == take_r) begin
            // Last byte handed out: the excess and the newline go with it.
            out_last_nxt = 1'b1;
            rp_nxt       = line_end_r;
            out_fill_nxt = fill_of(wp_r, line_end_r, 1'b0);
            state_nxt    = S_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            rp_nxt       = AW'(rp_r + AW'(1));
            out_fill_nxt = fill_of(wp_r, AW'(rp_r + AW'(1)), 1'b0);
            k_nxt        = CAP_W'(k_r + CAP_W'(1));
            rd_addr      = AW'(rp_r + AW'(1));
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
      cmd_mode_r  <= 1'b1;
      max_len_r   <= CAP_W'(urlrb_pkg::MAX_LINE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      full_r      <= full_nxt;
      cmd_mode_r  <= cmd_mode_nxt;
      max_len_r   <= max_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    have_r        <= have_nxt;
    len_r         <= len_nxt;
    take_r        <= take_nxt;
    k_r           <= k_nxt;
    line_end_r    <= line_end_nxt;
    pend_status_r <= pend_status_nxt;
    pend_fill_r   <= pend_fill_nxt;
    out_status_r  <= out_status_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
    out_fill_r    <= out_fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_fill_r, out_byte_r};

endmodule

>>> sv/urlrb_checker.sv
// Port-level checks for the receive line ring buffer, bound to the top level.
module urlrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // The fill level can never exceed the store depth.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:8] <= 11'(urlrb_pkg::DEPTH))
    else $error("fill level beyond store depth");

  // Only line-byte results carry a byte, and every other result closes its request.
  a_non_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != urlrb_pkg::STS_LINE_BYTE |-> out_tdata[7:0] == 8'h00 && out_tlast)
    else $error("non-line result with data or without last");

  // A flush always leaves an empty store.
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == urlrb_pkg::STS_FLUSHED |-> out_tdata[18:8] == '0)
    else $error("flush reported a non-zero fill level");

endmodule

bind uart_rx_line_ring_buffer_unit urlrb_checker u_urlrb_checker (.*);
